// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files; hrl_out_buf includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_RST(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond) \
  `ASSERT_RST(name, clk, rstn, !(cond))

`endif

// ===== rtl/core/hrl_pkg.sv =====
`default_nettype none

package hrl_pkg;

  // Code memory size; write targets at or above it are dropped.
  localparam int unsigned CODE_SIZE = 65536;

  // Record type codes.
  localparam logic [7:0] RecData    = 8'h00;
  localparam logic [7:0] RecEof     = 8'h01;
  localparam logic [7:0] RecExtLin  = 8'h04;

  // Result kinds carried on the master tuser.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2
  } hrl_kind_e;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] addr;
    hrl_kind_e   kind;
  } hrl_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/hex_record_loader_top.sv =====
// Channel   | Direction | tdata (low bit up)                  | tuser
// s_axis    | in        | ch[7:0]                             | end_of_input
// m_axis    | out       | write_address[15:0], write_data[23:16] | result_kind[1:0]
//
// One character per cycle while s_axis_tready is high: each accepted transaction is
// parsed in the cycle it arrives and its result, if any, is registered in the
// output buffer. Sustained rate is one transaction per clock while it is not full.
// Reset returns the parser to line start with base address zero.
// A two-slot output buffer absorbs one stalled result; s_axis_tready drops
// only while both slots are full.
`default_nettype none

module hex_record_loader_top import hrl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  wire logic        s_axis_tuser,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // write_address[15:0], write_data[23:16]
  output logic [1:0]       m_axis_tuser    // result_kind[1:0]
);

  logic        accept;
  logic        full;
  logic        res_valid;
  hrl_result_t res;
  hrl_result_t out_res;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Parse characters and track record state.
  hrl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (s_axis_tdata),
    .eoi_i       (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Register results toward the master side.
  hrl_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (out_res)
  );

  assign m_axis_tdata = {out_res.data, out_res.addr};
  assign m_axis_tuser = out_res.kind;

endmodule

`default_nettype wire

// ===== rtl/core/hrl_core.sv =====
`default_nettype none

module hrl_core import hrl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  ch_i,
  input  wire logic        eoi_i,
  output logic             res_valid_o,
  output hrl_result_t      res_o
);

  typedef enum logic [1:0] {
    PH_LINE_START,
    PH_RECORD,
    PH_SKIP
  } phase_e;

  // Decode one hex digit: bit 4 set when the character is a digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  first_q, first_d;
  logic        pend_q, pend_d;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  ext_q, ext_d;
  logic [15:0] base_q, base_d;
  logic        fin_q, fin_d;

  logic        line_end;
  logic [4:0]  digit;
  logic [7:0]  byte_val;
  logic [8:0]  data_idx;
  logic [16:0] sum_lo;
  logic        hi_zero;
  logic        in_range;
  logic        last_data;

  assign line_end  = (ch_i == 8'h0D) || (ch_i == 8'h0A);
  assign digit     = hex_digit(ch_i);
  assign byte_val  = {first_q, digit[3:0]};

  // Form base + address + index modulo 2^32 and test it against the code size.
  assign data_idx  = pos_q - 9'd4;
  assign sum_lo    = {1'b0, addr_q} + {8'd0, data_idx};
  assign hi_zero   = ((base_q == 16'h0000) && !sum_lo[16]) ||
                     ((base_q == 16'hFFFF) && sum_lo[16]);
  assign in_range  = hi_zero && ({1'b0, sum_lo[15:0]} < 17'(CODE_SIZE));
  assign last_data = ({1'b0, data_idx} + 10'd1) >= {2'd0, count_q};

  // Parse one character against the current record state.
  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    pend_d      = pend_q;
    pos_d       = pos_q;
    count_d     = count_q;
    addr_d      = addr_q;
    type_d      = type_q;
    ext_d       = ext_q;
    base_d      = base_q;
    fin_d       = fin_q;
    res_valid_o = 1'b0;
    res_o.kind  = KIND_WRITE;
    res_o.addr  = 16'd0;
    res_o.data  = 8'd0;

    if (!fin_q) begin
      if (eoi_i) begin
        fin_d       = 1'b1;
        res_valid_o = 1'b1;
        res_o.kind  = (phase_q == PH_RECORD) ? KIND_ERROR : KIND_OK;
      end else begin
        unique case (phase_q)
          PH_LINE_START: begin
            if (!line_end) begin
              if (ch_i != 8'h3A) begin
                fin_d       = 1'b1;
                res_valid_o = 1'b1;
                res_o.kind  = KIND_ERROR;
              end else begin
                phase_d = PH_RECORD;
                pos_d   = 9'd0;
                pend_d  = 1'b0;
                first_d = 4'd0;
              end
            end
          end
          PH_SKIP: begin
            if (line_end) begin
              phase_d = PH_LINE_START;
            end
          end
          default: begin
            if (line_end || !digit[4]) begin
              fin_d       = 1'b1;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_ERROR;
            end else if (!pend_q) begin
              first_d = digit[3:0];
              pend_d  = 1'b1;
            end else begin
              // Take a complete byte of the record.
              pend_d = 1'b0;
              pos_d  = pos_q + 9'd1;
              if (pos_q == 9'd0) begin
                count_d = byte_val;
              end else if (pos_q == 9'd1) begin
                addr_d = {byte_val, 8'd0};
              end else if (pos_q == 9'd2) begin
                addr_d = {addr_q[15:8], byte_val};
              end else if (pos_q == 9'd3) begin
                type_d = byte_val;
                if (byte_val == RecEof) begin
                  fin_d       = 1'b1;
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_OK;
                end else if (byte_val == RecData) begin
                  if (count_q == 8'd0) begin
                    phase_d = PH_SKIP;
                  end
                end else if (byte_val != RecExtLin) begin
                  phase_d = PH_SKIP;
                end
              end else if (type_q == RecData) begin
                if (in_range) begin
                  res_valid_o = 1'b1;
                  res_o.kind  = KIND_WRITE;
                  res_o.addr  = sum_lo[15:0];
                  res_o.data  = byte_val;
                end
                if (last_data) begin
                  phase_d = PH_SKIP;
                end
              end else if (pos_q == 9'd4) begin
                ext_d = byte_val;
              end else begin
                base_d  = {ext_q, byte_val};
                phase_d = PH_SKIP;
              end
            end
          end
        endcase
      end
    end

    // Suppress results for characters that were not taken.
    if (!accept_i) begin
      res_valid_o = 1'b0;
    end
  end

  // Hold record state; advance it only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LINE_START;
      first_q <= 4'd0;
      pend_q  <= 1'b0;
      pos_q   <= 9'd0;
      count_q <= 8'd0;
      addr_q  <= 16'd0;
      type_q  <= 8'd0;
      ext_q   <= 8'd0;
      base_q  <= 16'd0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
      pend_q  <= pend_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      type_q  <= type_d;
      ext_q   <= ext_d;
      base_q  <= base_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrl_out_buf.sv =====
`default_nettype none
`include "assert_macros.svh"

module hrl_out_buf import hrl_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  hrl_result_t       push_data_i,
  output logic              full_o,
  output logic              m_valid_o,
  input  wire logic         m_ready_i,
  output hrl_result_t       m_data_o
);

  logic        out_valid_q;
  logic        skid_valid_q;
  hrl_result_t out_q;
  hrl_result_t skid_q;
  logic        pop;

  assign pop       = out_valid_q && m_ready_i;
  assign full_o    = skid_valid_q;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

  // Track which of the output and skid slots hold a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Move payload into the output slot or park it in the skid slot.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_data_i;
      end else begin
        out_q <= push_data_i;
      end
    end
  end

  `ASSERT_RST(a_skid_implies_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && skid_valid_q)
  `ASSERT_RST(a_skid_fill_on_stall, clk_i, rst_ni,
              $rose(skid_valid_q) |-> $past(out_valid_q && !m_ready_i))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import hrl_pkg::*;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 50;

  typedef enum logic [1:0] {
    AT_LINE_START,
    IN_RECORD,
    SKIPPING_LINE
  } parse_phase_e;

  typedef enum int unsigned {
    END_EOF_RECORD,
    END_INPUT_AT_LINE,
    END_INPUT_IN_RECORD,
    END_INPUT_IN_SKIP,
    END_BAD_LINE_START,
    END_BAD_DIGIT,
    END_EARLY_LINE_END
  } end_case_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // ch[7:0]
  logic        s_axis_tuser = 1'b0;    // end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // write_address[15:0], write_data[23:16]
  logic [1:0]  m_axis_tuser;           // result_kind[1:0]

  // Parser shadow state
  parse_phase_e phase = AT_LINE_START;
  logic [3:0]   first_nibble = '0;
  logic         nibble_pending = 1'b0;
  logic [8:0]   byte_pos = '0;
  logic [7:0]   rec_count = '0;
  logic [15:0]  rec_addr = '0;
  logic [7:0]   rec_type = '0;
  logic [7:0]   ext_high = '0;
  logic [15:0]  base_upper = '0;
  logic         loader_done = 1'b0;

  hrl_result_t  predicted_loads[$];
  logic [7:0]   payload_q[$];
  int unsigned  chars_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  mismatch_count = 0;
  bit           long_hold_req = 1'b0;

  hex_record_loader_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return 10 + int'(c - "a");
    if (c >= "A" && c <= "F") return 10 + int'(c - "A");
    return -1;
  endfunction

  function automatic void push_load(input hrl_kind_e kind, input logic [15:0] addr,
                                    input logic [7:0] data);
    hrl_result_t r;
    r.kind = kind;
    r.addr = addr;
    r.data = data;
    predicted_loads.push_back(r);
  endfunction

  function automatic void finish_load(input hrl_kind_e kind);
    loader_done = 1'b1;
    push_load(kind, 16'h0000, 8'h00);
  endfunction

  // Advance the shadow parser by one character and queue what it produces
  function automatic void parse_hex_char(input logic [7:0] c, input logic eoi);
    int          v;
    logic [7:0]  b;
    logic [8:0]  p;
    logic [31:0] target;
    logic        line_end;
    line_end = (c == CharCr) || (c == CharLf);
    if (loader_done) return;
    if (eoi) begin
      finish_load(phase == IN_RECORD ? KIND_ERROR : KIND_OK);
      return;
    end
    case (phase)
      AT_LINE_START: begin
        if (line_end) return;
        if (c != CharColon) begin
          finish_load(KIND_ERROR);
          return;
        end
        phase = IN_RECORD;
        byte_pos = '0;
        nibble_pending = 1'b0;
        first_nibble = '0;
      end
      SKIPPING_LINE: begin
        if (line_end) phase = AT_LINE_START;
      end
      default: begin
        v = char_digit(c);
        if (line_end || v < 0) begin
          finish_load(KIND_ERROR);
          return;
        end
        if (!nibble_pending) begin
          first_nibble = v[3:0];
          nibble_pending = 1'b1;
          return;
        end
        nibble_pending = 1'b0;
        b = {first_nibble, v[3:0]};
        p = byte_pos;
        byte_pos = p + 9'd1;
        if (p == 9'd0) begin
          rec_count = b;
        end else if (p == 9'd1) begin
          rec_addr = {b, 8'h00};
        end else if (p == 9'd2) begin
          rec_addr[7:0] = b;
        end else if (p == 9'd3) begin
          rec_type = b;
          if (b == RecEof) finish_load(KIND_OK);
          else if (b == RecData) begin
            if (rec_count == 8'd0) phase = SKIPPING_LINE;
          end else if (b != RecExtLin) phase = SKIPPING_LINE;
        end else if (rec_type == RecData) begin
          target = {base_upper, 16'h0000} + {16'h0000, rec_addr} + {23'd0, p} - 32'd4;
          if (target < CODE_SIZE) push_load(KIND_WRITE, target[15:0], b);
          if ({23'd0, p} - 32'd3 >= {24'd0, rec_count}) phase = SKIPPING_LINE;
        end else if (p == 9'd4) begin
          ext_high = b;
        end else begin
          base_upper = {ext_high, b};
          phase = SKIPPING_LINE;
        end
      end
    endcase
  endfunction

  // Predict on each accepted character, then check each accepted result
  always @(posedge clk_i) begin : monitor
    hrl_result_t want;
    logic [1:0]  got_kind;
    logic [15:0] got_addr;
    logic [7:0]  got_data;
    if (rst_ni && s_axis_tvalid && s_axis_tready) parse_hex_char(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_kind = m_axis_tuser;
      got_addr = m_axis_tdata[15:0];
      got_data = m_axis_tdata[23:16];
      if (predicted_loads.size() == 0) begin
        $error("unexpected result: result_kind %0d write_address %h write_data %h",
               got_kind, got_addr, got_data);
        mismatch_count++;
      end else begin
        want = predicted_loads.pop_front();
        if (got_kind !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, got_kind);
          mismatch_count++;
        end
        if (got_addr !== want.addr) begin
          $error("write_address: expected %h, actual %h", want.addr, got_addr);
          mismatch_count++;
        end
        if (got_data !== want.data) begin
          $error("write_data: expected %h, actual %h", want.data, got_data);
          mismatch_count++;
        end
      end
    end
  end

  // Result sink: changing stall patterns, plus one long hold on request
  initial begin : sink
    int unsigned mode;
    int unsigned run_len;
    int unsigned k;
    forever begin
      mode = $urandom_range(0, 3);
      run_len = $urandom_range(10, 80);
      for (k = 0; k < run_len; k++) begin
        @(posedge clk_i);
        if (long_hold_req) begin
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
          long_hold_req = 1'b0;
        end
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2: m_axis_tready <= (k % 3 == 0);
          default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one character; idle between bursts; return once the transaction is taken
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tuser <= eoi;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  task automatic send_hex_byte(input logic [7:0] b);
    send_char(nibble_char(b[7:4]));
    send_char(nibble_char(b[3:0]));
  endtask

  // Any byte except a line end
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CharCr || c == CharLf);
    return c;
  endfunction

  task automatic send_line_end();
    case ($urandom_range(0, 3))
      0: send_char(CharCr);
      1: send_char(CharLf);
      2: begin
        send_char(CharCr);
        send_char(CharLf);
      end
      default: begin
        send_char(CharLf);
        send_char(CharLf);
      end
    endcase
  endtask

  // One full line: header, payload_q, checksum, optional trailing junk, line end
  task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                             input logic [7:0] rtype);
    logic [7:0] sum;
    int         i;
    int         n;
    sum = count + addr[15:8] + addr[7:0] + rtype;
    send_char(CharColon);
    send_hex_byte(count);
    send_hex_byte(addr[15:8]);
    send_hex_byte(addr[7:0]);
    send_hex_byte(rtype);
    for (i = 0; i < payload_q.size(); i++) begin
      sum = sum + payload_q[i];
      send_hex_byte(payload_q[i]);
    end
    // checksum is not checked by the block, so a wrong one must pass too
    if ($urandom_range(0, 3) != 0) send_hex_byte(8'h00 - sum);
    else send_hex_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_char(noise_char());
    end
    send_line_end();
  endtask

  function automatic logic [7:0] random_data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_data_record(input logic [7:0] count, input logic [15:0] addr);
    int i;
    payload_q.delete();
    for (i = 0; i < count; i++) payload_q.push_back(random_data_byte());
    send_record(count, addr, RecData);
  endtask

  task automatic send_random_data_record();
    logic [7:0]  count;
    logic [15:0] addr;
    count = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 16));
    addr = ($urandom_range(0, 2) == 0) ? 16'(16'hFFFF - $urandom_range(0, 20))
                                       : 16'($urandom_range(0, 65535));
    send_data_record(count, addr);
  endtask

  task automatic send_ext_record(input logic [15:0] base);
    logic [7:0] count;
    count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h02;
    payload_q.delete();
    payload_q.push_back(base[15:8]);
    payload_q.push_back(base[7:0]);
    send_record(count, 16'($urandom_range(0, 65535)), RecExtLin);
  endtask

  task automatic test_directed();
    send_char(CharCr);
    send_char(CharLf);
    // top of memory: two writes land, the third target is out of range
    send_text(":03FFFE00FF00a5");
    send_char(CharLf);
    send_text(":00000003");
    send_char(CharCr);
  endtask

  task automatic test_data_records();
    int unsigned stop_at;
    stop_at = chars_sent + 600;
    // one record of the largest count
    send_data_record(8'hFF, 16'($urandom_range(0, 65535)));
    while (chars_sent < stop_at) send_random_data_record();
  endtask

  task automatic test_extended_address();
    int unsigned stop_at;
    stop_at = chars_sent + 300;
    while (chars_sent < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: send_ext_record(16'hFFFF);
          1: send_ext_record(16'($urandom_range(1, 65535)));
          default: send_ext_record(16'h0000);
        endcase
      end else begin
        send_random_data_record();
      end
    end
    // leave the base at zero so later writes land
    send_ext_record(16'h0000);
  endtask

  task automatic test_skipped_lines();
    int unsigned stop_at;
    logic [7:0]  rtype;
    int          i;
    int          n;
    stop_at = chars_sent + 200;
    while (chars_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0: send_line_end();
        1: begin
          do rtype = 8'($urandom_range(0, 255));
          while (rtype == RecData || rtype == RecEof || rtype == RecExtLin);
          send_char(CharColon);
          send_hex_byte(8'($urandom_range(0, 255)));
          send_hex_byte(8'($urandom_range(0, 255)));
          send_hex_byte(8'($urandom_range(0, 255)));
          send_hex_byte(rtype);
          n = $urandom_range(0, 8);
          for (i = 0; i < n; i++) send_char(noise_char());
          send_line_end();
        end
        2: send_data_record(8'd0, 16'($urandom_range(0, 65535)));
        default: send_random_data_record();
      endcase
    end
  endtask

  // Stall the sink for a long stretch while characters keep coming
  task automatic test_output_backpressure();
    int unsigned stop_at;
    stop_at = chars_sent + 250;
    long_hold_req = 1'b1;
    burst_left = 400;
    while (chars_sent < stop_at)
      send_data_record(8'($urandom_range(4, 16)), 16'($urandom_range(0, 16'hFFE0)));
  endtask

  // End the load one of several ways, then show that later input is dropped
  task automatic test_termination();
    end_case_e  how;
    logic [7:0] c;
    int         i;
    how = end_case_e'($urandom_range(0, 6));
    case (how)
      END_EOF_RECORD: begin
        send_text(":00000001FF");
        send_line_end();
      end
      END_INPUT_AT_LINE: send_item(8'($urandom_range(0, 255)), 1'b1);
      END_INPUT_IN_RECORD: begin
        send_text(":01");
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_INPUT_IN_SKIP: begin
        send_text(":00000005");
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      END_BAD_LINE_START: begin
        do c = noise_char(); while (c == CharColon);
        send_char(c);
      end
      END_BAD_DIGIT: begin
        // bytes written before the bad digit stay written
        send_char(CharColon);
        send_hex_byte(8'h04);
        send_hex_byte(8'($urandom_range(0, 255)));
        send_hex_byte(8'($urandom_range(0, 255)));
        send_hex_byte(RecData);
        send_hex_byte(random_data_byte());
        send_hex_byte(random_data_byte());
        do c = noise_char(); while (char_digit(c) >= 0);
        send_char(c);
      end
      default: begin
        send_text(":0100");
        send_char(($urandom_range(0, 1) == 0) ? CharCr : CharLf);
      end
    endcase
    for (i = 0; i < 12; i++) begin
      c = (i % 4 == 0) ? CharColon : 8'($urandom_range(0, 255));
      send_item(c, ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_data_records();
    test_extended_address();
    test_skipped_lines();
    test_output_backpressure();
    test_termination();
    s_axis_tvalid <= 1'b0;
    while (predicted_loads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== hex_record_loader_top.f =====
+incdir+rtl/core
rtl/core/hrl_pkg.sv
rtl/core/hrl_core.sv
rtl/core/hrl_out_buf.sv
rtl/core/hex_record_loader_top.sv
tb/tb.sv
